>>> rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int CW   = 24;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int DOTW = PW + 2;
  localparam int QB   = 16;
  localparam int QW   = QB + 1;
  localparam int W1   = 2 * DOTW + 1;
  localparam int W2   = 72;
  localparam int OW   = 50;

  localparam logic [QW-1:0] ONE_Q16 = 17'h10000;
  localparam logic signed [DOTW-1:0] EPS_LEN = 52'sd43;
  localparam logic signed [W1-1:0] EPS_DEN = 105'sd184467440737;

  typedef logic signed [DW-1:0] diff_t;
  typedef diff_t [2:0] dvec_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic [QW-1:0] q_t;

  typedef struct packed {
    dvec_t d1;
    dvec_t d2;
    dvec_t r;
  } vset_t;

  typedef struct packed {
    vset_t v;
    dot_t  b;
    dot_t  e;
    dot_t  f;
    logic  adeg;
    logic  edeg;
  } mid_t;

  typedef struct packed {
    vset_t v;
    q_t    s0;
    q_t    s1;
    q_t    s2;
    logic  adeg;
    logic  edeg;
    logic  tneg;
    logic  tbig;
  } tsb_t;

endpackage

>>> rtl/ssd_fdiv.sv
module ssd_fdiv import ssd_pkg::*; #(
  parameter int W  = 72,
  parameter int NL = 1,
  parameter int SW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NL-1:0][W-1:0]  in_num,
  input  logic [NL-1:0][W-1:0]  in_den,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  input  logic                  out_stall,
  output q_t   [NL-1:0]         out_q,
  output logic [SW-1:0]         out_side
);

  localparam int NS = QB + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   hold;

  logic [NL-1:0][W-1:0]  rem_r  [NS];
  logic [NL-1:0][W-1:0]  den_r  [NS];
  logic [NL-1:0][QB-1:0] q_r    [NS];
  logic [NL-1:0]         zero_r [NS];
  logic [NL-1:0]         one_r  [NS];
  logic [SW-1:0]         side_r [NS];

  logic [NL-1:0] zero_nxt;
  logic [NL-1:0] one_nxt;

  assign hold[NS]     = out_stall;
  assign hold[NS-1:0] = v_r & hold[NS:1];
  assign in_stall     = hold[0];
  assign v_nxt        = (v_r & hold[NS-1:0]) | ({v_r[NS-2:0], in_valid} & ~hold[NS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // operand classes: non-positive gives zero, num >= den gives one
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      zero_nxt[l] = in_den[l][W-1] || !(|in_den[l]) || in_num[l][W-1] || !(|in_num[l]);
      one_nxt[l]  = !($signed(in_num[l]) < $signed(in_den[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      rem_r[0]  <= in_num;
      den_r[0]  <= in_den;
      q_r[0]    <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= one_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [NL-1:0][W-1:0]  sh_w;
    logic [NL-1:0][W-1:0]  rem_nxt;
    logic [NL-1:0][QB-1:0] q_nxt;

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        sh_w[l] = {rem_r[k-1][l][W-2:0], 1'b0};
        if (sh_w[l] >= den_r[k-1][l]) begin
          rem_nxt[l] = sh_w[l] - den_r[k-1][l];
          q_nxt[l]   = {q_r[k-1][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[l] = sh_w[l];
          q_nxt[l]   = {q_r[k-1][l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!hold[k]) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_nxt;
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      priority if (zero_r[NS-1][l]) begin
        out_q[l] = '0;
      end else if (one_r[NS-1][l]) begin
        out_q[l] = ONE_Q16;
      end else begin
        out_q[l] = {1'b0, q_r[NS-1][l]};
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

>>> rtl/ssd_front.sv
module ssd_front import ssd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [11:0][CW-1:0]   in_pt,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0][W1-1:0]    out_num,
  output logic [2:0][W1-1:0]    out_den,
  output mid_t                  out_side
);

  localparam int NS    = 6;
  localparam int HALF  = DOTW / 2;
  localparam int PRW   = 2 * HALF + 2;
  localparam int LNW   = DOTW + 1;
  localparam int DOT_A = 0;
  localparam int DOT_E = 1;
  localparam int DOT_F = 2;
  localparam int DOT_C = 3;
  localparam int DOT_B = 4;
  localparam int P_AE  = 0;
  localparam int P_BB  = 1;
  localparam int P_BF  = 2;
  localparam int P_CE  = 3;

  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [PRW-1:0] pw_t;
  typedef logic signed [W1-1:0]  wide_t;
  typedef logic signed [LNW-1:0] ln_t;
  typedef struct packed {
    pw_t hh;
    pw_t lh;
    pw_t hl;
    pw_t ll;
  } part_t;

  function automatic part_t mpart(input dot_t x, input dot_t y);
    logic signed [HALF:0]   xl;
    logic signed [HALF:0]   yl;
    logic signed [HALF-1:0] xh;
    logic signed [HALF-1:0] yh;
    part_t p;
    xl   = {1'b0, x[HALF-1:0]};
    yl   = {1'b0, y[HALF-1:0]};
    xh   = x[DOTW-1:HALF];
    yh   = y[DOTW-1:HALF];
    p.hh = xh * yh;
    p.lh = xl * yh;
    p.hl = xh * yl;
    p.ll = xl * yl;
    return p;
  endfunction

  function automatic wide_t mjoin(input part_t p);
    return (W1'(p.hh) <<< (2 * HALF)) + ((W1'(p.lh) + W1'(p.hl)) <<< HALF) + W1'(p.ll);
  endfunction

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   hold;

  vset_t vs1_r, vs1_nxt, vs2_r, vs3_r, vs4_r, vs5_r;
  prod_t [4:0][2:0] pr2_r, pr2_nxt;
  dot_t  a3_r, e3_r, f3_r, c3_r, b3_r;
  dot_t  a4_r, e4_r, f4_r, b4_r;
  part_t [3:0] part4_r, part4_nxt;
  ln_t   ln1_4_r, ln2_4_r;
  logic  adeg4_r, edeg4_r, adeg5_r, edeg5_r;
  wide_t ae5_r, bb5_r, bf5_r, ce5_r;
  dot_t  a5_r, e5_r, f5_r, b5_r;
  ln_t   ln1_5_r, ln2_5_r;
  wide_t den_w, nums_w;
  logic [2:0][W1-1:0] num6_r, den6_r, num6_nxt, den6_nxt;
  mid_t  side6_r;

  assign hold[NS]     = out_stall;
  assign hold[NS-1:0] = v_r & hold[NS:1];
  assign in_stall     = hold[0];
  assign v_nxt        = (v_r & hold[NS-1:0]) | ({v_r[NS-2:0], in_valid} & ~hold[NS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vs1_nxt.d1[i] = DW'($signed(in_pt[3+i])) - DW'($signed(in_pt[i]));
      vs1_nxt.d2[i] = DW'($signed(in_pt[9+i])) - DW'($signed(in_pt[6+i]));
      vs1_nxt.r[i]  = DW'($signed(in_pt[i])) - DW'($signed(in_pt[6+i]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr2_nxt[DOT_A][i] = $signed(vs1_r.d1[i]) * $signed(vs1_r.d1[i]);
      pr2_nxt[DOT_E][i] = $signed(vs1_r.d2[i]) * $signed(vs1_r.d2[i]);
      pr2_nxt[DOT_F][i] = $signed(vs1_r.d2[i]) * $signed(vs1_r.r[i]);
      pr2_nxt[DOT_C][i] = $signed(vs1_r.d1[i]) * $signed(vs1_r.r[i]);
      pr2_nxt[DOT_B][i] = $signed(vs1_r.d1[i]) * $signed(vs1_r.d2[i]);
    end
  end

  // wide products split into half-width partials
  always_comb begin
    part4_nxt[P_AE] = mpart(a3_r, e3_r);
    part4_nxt[P_BB] = mpart(b3_r, b3_r);
    part4_nxt[P_BF] = mpart(b3_r, f3_r);
    part4_nxt[P_CE] = mpart(c3_r, e3_r);
  end

  assign den_w  = ae5_r - bb5_r;
  assign nums_w = bf5_r - ce5_r;

  always_comb begin
    // near parallel or first segment a point: s starts at zero
    if (adeg5_r || (den_w <= EPS_DEN)) begin
      num6_nxt[0] = '0;
    end else begin
      num6_nxt[0] = nums_w;
    end
    den6_nxt[0] = den_w;
    num6_nxt[1] = W1'(ln1_5_r);
    den6_nxt[1] = W1'(a5_r);
    num6_nxt[2] = W1'(ln2_5_r);
    den6_nxt[2] = W1'(a5_r);
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      vs1_r <= vs1_nxt;
    end
    if (!hold[1]) begin
      vs2_r <= vs1_r;
      pr2_r <= pr2_nxt;
    end
    if (!hold[2]) begin
      vs3_r <= vs2_r;
      a3_r  <= DOTW'($signed(pr2_r[DOT_A][0])) + DOTW'($signed(pr2_r[DOT_A][1]))
             + DOTW'($signed(pr2_r[DOT_A][2]));
      e3_r  <= DOTW'($signed(pr2_r[DOT_E][0])) + DOTW'($signed(pr2_r[DOT_E][1]))
             + DOTW'($signed(pr2_r[DOT_E][2]));
      f3_r  <= DOTW'($signed(pr2_r[DOT_F][0])) + DOTW'($signed(pr2_r[DOT_F][1]))
             + DOTW'($signed(pr2_r[DOT_F][2]));
      c3_r  <= DOTW'($signed(pr2_r[DOT_C][0])) + DOTW'($signed(pr2_r[DOT_C][1]))
             + DOTW'($signed(pr2_r[DOT_C][2]));
      b3_r  <= DOTW'($signed(pr2_r[DOT_B][0])) + DOTW'($signed(pr2_r[DOT_B][1]))
             + DOTW'($signed(pr2_r[DOT_B][2]));
    end
    if (!hold[3]) begin
      vs4_r   <= vs3_r;
      part4_r <= part4_nxt;
      a4_r    <= a3_r;
      e4_r    <= e3_r;
      f4_r    <= f3_r;
      b4_r    <= b3_r;
      ln1_4_r <= -LNW'(c3_r);
      ln2_4_r <= LNW'(b3_r) - LNW'(c3_r);
      adeg4_r <= a3_r <= EPS_LEN;
      edeg4_r <= e3_r <= EPS_LEN;
    end
    if (!hold[4]) begin
      vs5_r   <= vs4_r;
      ae5_r   <= mjoin(part4_r[P_AE]);
      bb5_r   <= mjoin(part4_r[P_BB]);
      bf5_r   <= mjoin(part4_r[P_BF]);
      ce5_r   <= mjoin(part4_r[P_CE]);
      a5_r    <= a4_r;
      e5_r    <= e4_r;
      f5_r    <= f4_r;
      b5_r    <= b4_r;
      ln1_5_r <= ln1_4_r;
      ln2_5_r <= ln2_4_r;
      adeg5_r <= adeg4_r;
      edeg5_r <= edeg4_r;
    end
    if (!hold[5]) begin
      num6_r       <= num6_nxt;
      den6_r       <= den6_nxt;
      side6_r.v    <= vs5_r;
      side6_r.b    <= b5_r;
      side6_r.e    <= e5_r;
      side6_r.f    <= f5_r;
      side6_r.adeg <= adeg5_r;
      side6_r.edeg <= edeg5_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_num   = num6_r;
  assign out_den   = den6_r;
  assign out_side  = side6_r;

endmodule

>>> rtl/ssd_mid.sv
module ssd_mid import ssd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  q_t   [2:0]     in_q,
  input  mid_t           in_side,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [W2-1:0]  out_num,
  output logic [W2-1:0]  out_den,
  output tsb_t           out_side
);

  localparam int NS  = 2;
  localparam int BSW = DOTW + QW + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   hold;

  logic signed [BSW-1:0] bs1_r;
  mid_t                  sd1_r;
  q_t   [2:0]            q1_r;
  logic signed [W2-1:0]  tn_w, ed_w;
  logic [W2-1:0]         num2_r, den2_r;
  tsb_t                  tsb2_r;

  assign hold[NS]     = out_stall;
  assign hold[NS-1:0] = v_r & hold[NS:1];
  assign in_stall     = hold[0];
  assign v_nxt        = (v_r & hold[NS-1:0]) | ({v_r[NS-2:0], in_valid} & ~hold[NS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // t numerator and denominator, both scaled by one in Q1.16
  assign tn_w = W2'(bs1_r) + (W2'(sd1_r.f) <<< QB);
  assign ed_w = W2'(sd1_r.e) <<< QB;

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      bs1_r <= in_side.b * $signed({1'b0, in_q[0]});
      sd1_r <= in_side;
      q1_r  <= in_q;
    end
    if (!hold[1]) begin
      num2_r      <= tn_w;
      den2_r      <= ed_w;
      tsb2_r.v    <= sd1_r.v;
      tsb2_r.s0   <= q1_r[0];
      tsb2_r.s1   <= q1_r[1];
      tsb2_r.s2   <= q1_r[2];
      tsb2_r.adeg <= sd1_r.adeg;
      tsb2_r.edeg <= sd1_r.edeg;
      tsb2_r.tneg <= tn_w[W2-1];
      tsb2_r.tbig <= ed_w < tn_w;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_num   = num2_r;
  assign out_den   = den2_r;
  assign out_side  = tsb2_r;

endmodule

>>> rtl/ssd_tail.sv
module ssd_tail import ssd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  q_t             in_q,
  input  tsb_t           in_side,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [OW-1:0]  out_ds
);

  localparam int NS  = 5;
  localparam int DCW = DW + QB + 2;
  localparam int LOW = DCW / 2;
  localparam int HIW = DCW - LOW;
  localparam int PQW = 2 * HIW;
  localparam int SQW = 2 * DCW + 2;
  localparam int SH  = 2 * QB;

  localparam logic [SQW-1:0] RND = SQW'(1) << (SH - 1);

  typedef logic signed [DCW-1:0] dc_t;
  typedef logic signed [PQW-1:0] pq_t;
  typedef logic [SQW-1:0]        sq_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   hold;

  q_t         s1_r, t1_r, s1_nxt, t1_nxt;
  vset_t      vs1_r, vs2_r;
  dc_t  [2:0] dc2_r, dc2_nxt;
  pq_t  [2:0] hh3_r, hl3_r, ll3_r, hh3_nxt, hl3_nxt, ll3_nxt;
  sq_t  [2:0] sq4_r, sq4_nxt;
  sq_t        sum_w;
  logic [OW-1:0] ds5_r;

  assign hold[NS]     = out_stall;
  assign hold[NS-1:0] = v_r & hold[NS:1];
  assign in_stall     = hold[0];
  assign v_nxt        = (v_r & hold[NS-1:0]) | ({v_r[NS-2:0], in_valid} & ~hold[NS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    priority if (in_side.adeg && in_side.edeg) begin
      s1_nxt = '0;
      t1_nxt = '0;
    end else if (in_side.adeg) begin
      s1_nxt = '0;
      t1_nxt = in_q;
    end else if (in_side.edeg || in_side.tneg) begin
      s1_nxt = in_side.s1;
      t1_nxt = '0;
    end else if (in_side.tbig) begin
      s1_nxt = in_side.s2;
      t1_nxt = ONE_Q16;
    end else begin
      s1_nxt = in_side.s0;
      t1_nxt = in_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc2_nxt[i] = (DCW'($signed(vs1_r.r[i])) <<< QB)
                 + DCW'($signed(vs1_r.d1[i])) * $signed({1'b0, s1_r})
                 - DCW'($signed(vs1_r.d2[i])) * $signed({1'b0, t1_r});
    end
  end

  // square split into high and low halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh3_nxt[i] = $signed(dc2_r[i][DCW-1:LOW]) * $signed(dc2_r[i][DCW-1:LOW]);
      hl3_nxt[i] = $signed(dc2_r[i][DCW-1:LOW]) * $signed({1'b0, dc2_r[i][LOW-1:0]});
      ll3_nxt[i] = $signed({1'b0, dc2_r[i][LOW-1:0]}) * $signed({1'b0, dc2_r[i][LOW-1:0]});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_nxt[i] = (SQW'(hh3_r[i]) <<< (2 * LOW)) + (SQW'(hl3_r[i]) <<< (LOW + 1))
                 + SQW'(ll3_r[i]);
    end
  end

  assign sum_w = sq4_r[0] + sq4_r[1] + sq4_r[2] + RND;

  always_ff @(posedge clk) begin
    if (!hold[0]) begin
      s1_r  <= s1_nxt;
      t1_r  <= t1_nxt;
      vs1_r <= in_side.v;
    end
    if (!hold[1]) begin
      dc2_r <= dc2_nxt;
    end
    if (!hold[2]) begin
      hh3_r <= hh3_nxt;
      hl3_r <= hl3_nxt;
      ll3_r <= ll3_nxt;
    end
    if (!hold[3]) begin
      sq4_r <= sq4_nxt;
    end
    if (!hold[4]) begin
      ds5_r <= sum_w[SH+OW-1:SH];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_ds    = ds5_r;

endmodule

>>> rtl/segment_segment_distance_sq.sv
// Squared distance between the closest points of two 3-D segments given in signed Q8.16,
// returned as unsigned Q.32 rounded to nearest. A new segment pair can be taken every clock while
// in_stall is low, and each pair passes 47 register stages: 6 stages of differences, dot
// products and split wide products, the first fraction divider (s and its two re-clamp
// alternatives, one quotient bit per stage), the forming of the t numerator and denominator,
// the t divider and the selection of s and t with the sum of the squares. Every stage holds its
// own valid bit, so a stall on the result side fills empty stages before in_stall is raised.
module segment_segment_distance_sq import ssd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_first_start_x,
  input  logic signed [CW-1:0] in_first_start_y,
  input  logic signed [CW-1:0] in_first_start_z,
  input  logic signed [CW-1:0] in_first_end_x,
  input  logic signed [CW-1:0] in_first_end_y,
  input  logic signed [CW-1:0] in_first_end_z,
  input  logic signed [CW-1:0] in_second_start_x,
  input  logic signed [CW-1:0] in_second_start_y,
  input  logic signed [CW-1:0] in_second_start_z,
  input  logic signed [CW-1:0] in_second_end_x,
  input  logic signed [CW-1:0] in_second_end_y,
  input  logic signed [CW-1:0] in_second_end_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OW-1:0]        out_distance_squared
);

  logic [11:0][CW-1:0] pt_w;

  logic               f_valid, f_stall;
  logic [2:0][W1-1:0] f_num, f_den;
  mid_t               f_side;

  logic               d1_valid, d1_stall;
  q_t   [2:0]         d1_q;
  logic [$bits(mid_t)-1:0] d1_side_w;
  mid_t               d1_side;

  logic               m_valid, m_stall;
  logic [W2-1:0]      m_num, m_den;
  tsb_t               m_side;

  logic               d2_valid, d2_stall;
  q_t   [0:0]         d2_q;
  logic [$bits(tsb_t)-1:0] d2_side_w;
  tsb_t               d2_side;

  assign pt_w = {in_second_end_z, in_second_end_y, in_second_end_x,
                 in_second_start_z, in_second_start_y, in_second_start_x,
                 in_first_end_z, in_first_end_y, in_first_end_x,
                 in_first_start_z, in_first_start_y, in_first_start_x};

  ssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pt     (pt_w),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_side  (f_side)
  );

  ssd_fdiv #(
    .W  (W1),
    .NL (3),
    .SW ($bits(mid_t))
  ) u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (d1_valid),
    .out_stall (d1_stall),
    .out_q     (d1_q),
    .out_side  (d1_side_w)
  );

  assign d1_side = mid_t'(d1_side_w);

  ssd_mid u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_stall  (d1_stall),
    .in_q      (d1_q),
    .in_side   (d1_side),
    .out_valid (m_valid),
    .out_stall (m_stall),
    .out_num   (m_num),
    .out_den   (m_den),
    .out_side  (m_side)
  );

  ssd_fdiv #(
    .W  (W2),
    .NL (1),
    .SW ($bits(tsb_t))
  ) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_stall  (m_stall),
    .in_num    (m_num),
    .in_den    (m_den),
    .in_side   (m_side),
    .out_valid (d2_valid),
    .out_stall (d2_stall),
    .out_q     (d2_q),
    .out_side  (d2_side_w)
  );

  assign d2_side = tsb_t'(d2_side_w);

  ssd_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_stall  (d2_stall),
    .in_q      (d2_q[0]),
    .in_side   (d2_side),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ds    (out_distance_squared)
  );

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while result side is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_t_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    d2_valid |-> !(d2_side.tneg && d2_side.tbig))
    else $error("t clamped both low and high");

endmodule
